FILE: rtl/core/jtt_pkg.sv
// Shared types and constants for the journal transaction tracker.
// No dependencies; used by jtt_log_ram and journal_transaction_tracker.
package jtt_pkg;

  localparam int LOG_ENTRIES_DEF          = 32;
  localparam int BLOCKS_PER_OPERATION_DEF = 8;

  localparam int CNT_W   = 6;   // open operation count and entries used
  localparam int CFG_W   = 13;  // log area size register
  localparam int BLK_W   = 32;  // disk block number
  localparam int CMD_W   = 2;
  localparam int NEED_W  = 13;  // worst-case entry demand of a begin

  localparam logic [CNT_W-1:0] COUNT_MAX       = 6'd63;
  localparam logic [CFG_W-1:0] LOG_AREA_RESET  = 13'd33;

  localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_END   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_REFUSED  = 3'd1,
    ST_ENDED    = 3'd2,
    ST_COMMIT   = 3'd3,
    ST_ABSORBED = 3'd4,
    ST_APPENDED = 3'd5,
    ST_FULL     = 3'd6,
    ST_NO_OPEN  = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

endpackage

FILE: rtl/core/jtt_log_ram.sv
// Table of logged block numbers: one write port, one read port, registered read.
// Depends on jtt_pkg for the block number width.
module jtt_log_ram #(
  parameter int DEPTH = jtt_pkg::LOG_ENTRIES_DEF,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [jtt_pkg::BLK_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [jtt_pkg::BLK_W-1:0] rd_data
);

  logic [jtt_pkg::BLK_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/journal_transaction_tracker.sv
// Top level of the group-commit log tracker: sequencer, counters, result register.
// Depends on jtt_pkg and jtt_log_ram.
//
//  channel   handshake                 payload
//  --------  ------------------------  -----------------------------------
//  command   start && !busy            cmd, block_number
//  result    done (one cycle, no hold) status, block_number_out, last
//  config    cfg_valid && cfg_ready    cfg_data (log_area_blocks)
//
// Begin, end without commit, refused or flagged writes and a write into an empty
// table are handled in idle: busy stays low and the result shows in the next cycle.
// A write into a non-empty table walks the table on the RAM read port, one entry a
// cycle, up to entries_used entries. A commit emits entries_used entries, one a
// cycle, with busy high until the last is issued. No clearing pass after reset:
// only entries below entries_used are read. Results cannot stall; cfg_ready is 1.
module journal_transaction_tracker #(
  parameter int LOG_ENTRIES          = jtt_pkg::LOG_ENTRIES_DEF,
  parameter int BLOCKS_PER_OPERATION = jtt_pkg::BLOCKS_PER_OPERATION_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [jtt_pkg::CMD_W-1:0]   cmd,
  input  logic [jtt_pkg::BLK_W-1:0]   block_number,
  output logic                        done,
  output logic [2:0]                  status,
  output logic [jtt_pkg::BLK_W-1:0]   block_number_out,
  output logic                        last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [jtt_pkg::CFG_W-1:0]   cfg_data
);

  localparam int IDX_W = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;
  localparam int CW    = jtt_pkg::CNT_W;

  jtt_pkg::state_t             state, state_next;
  logic [CW-1:0]               open_ops, open_ops_next;
  logic [CW-1:0]               entries, entries_next;
  logic [IDX_W-1:0]            idx, idx_next;
  logic [jtt_pkg::BLK_W-1:0]   key;
  logic [jtt_pkg::CFG_W-1:0]   log_area;

  logic                        done_next;
  jtt_pkg::status_t            status_reg, status_next;
  logic [jtt_pkg::BLK_W-1:0]   block_number_out_next;
  logic                        last_next;

  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;
  logic [jtt_pkg::BLK_W-1:0]   wr_data;
  logic [IDX_W-1:0]            rd_addr;
  logic [jtt_pkg::BLK_W-1:0]   rd_data;

  logic                        accept;
  logic [IDX_W:0]              idx_inc;
  logic                        idx_last;
  logic [jtt_pkg::NEED_W-1:0]  need;
  logic [jtt_pkg::CFG_W-1:0]   limit;
  logic                        full;

  jtt_log_ram #(
    .DEPTH (LOG_ENTRIES)
  ) u_log_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy      = (state != jtt_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign status    = status_reg;

  assign idx_inc  = {1'b0, idx} + 1'b1;
  assign idx_last = ((CW+1)'(idx_inc) == (CW+1)'(entries));

  assign need = jtt_pkg::NEED_W'(entries)
              + (jtt_pkg::NEED_W'(open_ops) + 1'b1)
                * jtt_pkg::NEED_W'(BLOCKS_PER_OPERATION);

  assign limit = (log_area == '0) ? '0 : log_area - 1'b1;
  assign full  = ((CW+1)'(entries) >= (CW+1)'(LOG_ENTRIES))
              || (jtt_pkg::CFG_W'(entries) >= limit)
              || (entries == jtt_pkg::COUNT_MAX);

  always_comb begin
    state_next            = state;
    open_ops_next         = open_ops;
    entries_next          = entries;
    idx_next              = idx;
    done_next             = 1'b0;
    status_next           = jtt_pkg::ST_GRANTED;
    block_number_out_next = '0;
    last_next             = 1'b1;
    wr_en                 = 1'b0;
    wr_addr               = entries[IDX_W-1:0];
    wr_data               = key;
    rd_addr               = '0;

    unique case (state)
      jtt_pkg::S_IDLE: begin
        if (accept) begin
          idx_next = '0;
          unique case (cmd)
            jtt_pkg::CMD_BEGIN: begin
              done_next = 1'b1;
              if (open_ops == jtt_pkg::COUNT_MAX
                  || need > jtt_pkg::NEED_W'(LOG_ENTRIES)) begin
                status_next = jtt_pkg::ST_REFUSED;
              end else begin
                open_ops_next = open_ops + 1'b1;
                status_next   = jtt_pkg::ST_GRANTED;
              end
            end
            jtt_pkg::CMD_END: begin
              if (open_ops == '0) begin
                done_next   = 1'b1;
                status_next = jtt_pkg::ST_NO_OPEN;
              end else begin
                open_ops_next = open_ops - 1'b1;
                if (open_ops != CW'(1) || entries == '0) begin
                  done_next   = 1'b1;
                  status_next = jtt_pkg::ST_ENDED;
                end else begin
                  // entry 0 is read now and streamed out by S_COMMIT
                  state_next = jtt_pkg::S_COMMIT;
                end
              end
            end
            jtt_pkg::CMD_WRITE: begin
              if (full) begin
                done_next   = 1'b1;
                status_next = jtt_pkg::ST_FULL;
              end else if (open_ops == '0) begin
                done_next   = 1'b1;
                status_next = jtt_pkg::ST_NO_OPEN;
              end else if (entries == '0) begin
                wr_en        = 1'b1;
                wr_data      = block_number;
                entries_next = entries + 1'b1;
                done_next    = 1'b1;
                status_next  = jtt_pkg::ST_APPENDED;
              end else begin
                state_next = jtt_pkg::S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      jtt_pkg::S_SCAN: begin
        if (rd_data == key) begin
          done_next   = 1'b1;
          status_next = jtt_pkg::ST_ABSORBED;
          state_next  = jtt_pkg::S_IDLE;
        end else if (idx_last) begin
          // no match anywhere: append at the end of the table
          wr_en        = 1'b1;
          entries_next = entries + 1'b1;
          done_next    = 1'b1;
          status_next  = jtt_pkg::ST_APPENDED;
          state_next   = jtt_pkg::S_IDLE;
        end else begin
          idx_next = idx_inc[IDX_W-1:0];
          rd_addr  = idx_inc[IDX_W-1:0];
        end
      end
      jtt_pkg::S_COMMIT: begin
        done_next             = 1'b1;
        status_next           = jtt_pkg::ST_COMMIT;
        block_number_out_next = rd_data;
        last_next             = idx_last;
        if (idx_last) begin
          entries_next = '0;
          state_next   = jtt_pkg::S_IDLE;
        end else begin
          idx_next = idx_inc[IDX_W-1:0];
          rd_addr  = idx_inc[IDX_W-1:0];
        end
      end
      default: begin
        state_next = jtt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= jtt_pkg::S_IDLE;
      open_ops <= '0;
      entries  <= '0;
      log_area <= jtt_pkg::LOG_AREA_RESET;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      open_ops <= open_ops_next;
      entries  <= entries_next;
      done     <= done_next;
      if (cfg_valid && cfg_ready) begin
        log_area <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx              <= idx_next;
    status_reg       <= status_next;
    block_number_out <= block_number_out_next;
    last             <= last_next;
    if (accept) begin
      key <= block_number;
    end
  end

`ifndef SYNTH
  // a result only follows an accepted command or a cycle of table work
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a command in progress");

  // results that are not final come only from a commit still in progress
  a_not_last_busy: assert property (@(posedge clk) disable iff (rst)
    (done && !last) |-> (busy && status == jtt_pkg::ST_COMMIT))
    else $error("non-final result outside a commit");

  // busy rises only on an accepted command
  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command");
`endif

endmodule
